// ===== src/pad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pad_pkg;

  // Item opcodes. Code 3 has no meaning and leaves the state untouched.
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_ZERO_CROSS = 2'd1,
    OP_SET_LEVEL  = 2'd2
  } op_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_PULSE_LENGTH  = 2'd0;
  localparam logic [1:0] REG_SCALE_FACTOR  = 2'd1;
  localparam logic [1:0] REG_LEVEL_FLOOR   = 2'd2;
  localparam logic [1:0] REG_LEVEL_CEILING = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_PULSE_LENGTH  = 8'd5;
  localparam logic [7:0] RST_SCALE_FACTOR  = 8'd84;
  localparam logic [7:0] RST_LEVEL_FLOOR   = 8'd26;
  localparam logic [7:0] RST_LEVEL_CEILING = 8'd229;

  typedef struct packed {
    logic [7:0] pulse_length;
    logic [7:0] scale_factor;
    logic [7:0] level_floor;
    logic [7:0] level_ceiling;
  } cfg_t;

  // Command word handed from the input stage to the channel timer.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  channel;
    logic [11:0] delay;
  } cmd_t;

  // Timer state as it stands after the command.
  typedef struct packed {
    logic [3:0]  gates;
    logic [15:0] tick;
  } view_t;

endpackage

`default_nettype wire

// ===== src/pad_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pad_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] channel;
  logic [7:0] level;

  modport source (output valid, opcode, channel, level, input ready);
  modport sink (input valid, opcode, channel, level, output ready);
endinterface

`default_nettype wire

// ===== src/pad_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pad_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  gates;
  logic [15:0] tick_now;
  logic [11:0] delay_set;

  modport source (output valid, gates, tick_now, delay_set, input ready);
  modport sink (input valid, gates, tick_now, delay_set, output ready);
endinterface

`default_nettype wire

// ===== src/pad_conv.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pad_conv (
  input  pad_pkg::cfg_t cfg_i,
  input  logic [7:0]    level_i,
  output logic [11:0]   delay_o
);

  logic [7:0]  lvl_lo;
  logic [7:0]  lvl_cl;
  logic [15:0] prod;
  logic [7:0]  quot;

  // Floor clamp first, ceiling second, so the ceiling wins when they cross.
  assign lvl_lo = (level_i < cfg_i.level_floor) ? cfg_i.level_floor : level_i;
  assign lvl_cl = (lvl_lo > cfg_i.level_ceiling) ? cfg_i.level_ceiling : lvl_lo;
  assign prod   = 16'(lvl_cl) * 16'(cfg_i.scale_factor);
  assign quot   = prod[15:8];

  // Times ten as 8x + 2x; the largest value, 2540, fits in twelve bits.
  assign delay_o = 12'({quot, 3'b000}) + 12'({quot, 1'b0});

endmodule

`default_nettype wire

// ===== src/pad_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pad_timer #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  pad_pkg::cmd_t  cmd_i,
  input  logic [7:0]     pulse_length_i,
  output pad_pkg::view_t view_o
);

  logic [15:0]             tick_q, tick_d;
  logic [7:0]              pulse_q, pulse_d;
  logic [NUM_CHANNELS-1:0] gate_q, gate_d;
  logic [11:0]             pend_q [NUM_CHANNELS];
  logic [11:0]             pend_d [NUM_CHANNELS];
  logic [11:0]             act_q  [NUM_CHANNELS];
  logic [11:0]             act_d  [NUM_CHANNELS];

  always_comb begin
    tick_d  = tick_q;
    pulse_d = pulse_q;
    gate_d  = gate_q;
    pend_d  = pend_q;
    act_d   = act_q;
    if (adv_i) begin
      case (cmd_i.opcode)
        pad_pkg::OP_TICK: begin
          tick_d = tick_q + 16'd1;
          // A running pulse ends when its count reaches the pulse length.
          if (pulse_q != 8'd0) begin
            pulse_d = pulse_q + 8'd1;
            if (pulse_d == pulse_length_i) begin
              gate_d  = '0;
              pulse_d = 8'd0;
            end
          end
          for (int k = 0; k < NUM_CHANNELS; k++) begin
            if ({4'd0, act_q[k]} == tick_d) begin
              gate_d[k] = 1'b1;
              pulse_d   = 8'd1;
            end
          end
        end
        pad_pkg::OP_ZERO_CROSS: begin
          act_d  = pend_q;
          tick_d = '0;
        end
        pad_pkg::OP_SET_LEVEL: begin
          // A channel number beyond the last channel matches no entry.
          for (int k = 0; k < NUM_CHANNELS; k++) begin
            if ({1'b0, cmd_i.channel} == 3'(k)) begin
              pend_d[k] = cmd_i.delay;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      pulse_q <= '0;
      gate_q  <= '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        pend_q[k] <= '0;
        act_q[k]  <= '0;
      end
    end else begin
      tick_q  <= tick_d;
      pulse_q <= pulse_d;
      gate_q  <= gate_d;
      pend_q  <= pend_d;
      act_q   <= act_d;
    end
  end

  assign view_o.gates = 4'(gate_d);
  assign view_o.tick  = tick_d;

endmodule

`default_nettype wire

// ===== src/four_channel_phase_angle_dimmer.sv =====
// A word accepted at the input is loaded into the input register, then into the
// result register when it is free or being read. Throughput: one word per cycle
// unless the result side stalls; the input side keeps taking words while a
// result word waits, up to the one held in the input register.
// Reset (asynchronous, active low) empties both stages, clears counters,
// delays and gates, and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module four_channel_phase_angle_dimmer #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  pad_in_if.sink      in_i,
  pad_out_if.source   out_o
);

  pad_pkg::cfg_t  cfg_q;
  pad_pkg::cmd_t  cmd;
  pad_pkg::view_t view;

  logic        s1_valid_q;
  logic [1:0]  s1_opcode_q;
  logic [1:0]  s1_channel_q;
  logic [7:0]  s1_level_q;
  logic        s1_adv;
  logic        in_take;
  logic [11:0] delay;

  logic        out_valid_q;
  logic [3:0]  out_gates_q;
  logic [15:0] out_tick_q;
  logic [11:0] out_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_length  <= pad_pkg::RST_PULSE_LENGTH;
      cfg_q.scale_factor  <= pad_pkg::RST_SCALE_FACTOR;
      cfg_q.level_floor   <= pad_pkg::RST_LEVEL_FLOOR;
      cfg_q.level_ceiling <= pad_pkg::RST_LEVEL_CEILING;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pad_pkg::REG_PULSE_LENGTH:  cfg_q.pulse_length  <= cfg_wdata_i;
        pad_pkg::REG_SCALE_FACTOR:  cfg_q.scale_factor  <= cfg_wdata_i;
        pad_pkg::REG_LEVEL_FLOOR:   cfg_q.level_floor   <= cfg_wdata_i;
        pad_pkg::REG_LEVEL_CEILING: cfg_q.level_ceiling <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // The input stage moves on whenever the result register is free or being read.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_opcode_q  <= in_i.opcode;
      s1_channel_q <= in_i.channel;
      s1_level_q   <= in_i.level;
    end
  end

  pad_conv u_conv (
    .cfg_i   (cfg_q),
    .level_i (s1_level_q),
    .delay_o (delay)
  );

  assign cmd.opcode  = s1_opcode_q;
  assign cmd.channel = s1_channel_q;
  assign cmd.delay   = delay;

  pad_timer #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_timer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (s1_adv),
    .cmd_i          (cmd),
    .pulse_length_i (cfg_q.pulse_length),
    .view_o         (view)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_gates_q <= view.gates;
      out_tick_q  <= view.tick;
      out_delay_q <= (s1_opcode_q == pad_pkg::OP_SET_LEVEL) ? delay : 12'd0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.gates     = out_gates_q;
  assign out_o.tick_now  = out_tick_q;
  assign out_o.delay_set = out_delay_q;

endmodule

`default_nettype wire

// ===== src/pad_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  out_gates_i,
  input logic [15:0] out_tick_i,
  input logic [11:0] out_delay_i
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_gates_i) &&
    $stable(out_tick_i) && $stable(out_delay_i))
    else $error("result word changed while stalled");

  // With the result register empty the input register drains, so input is open.
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty result register");

  // No result word can appear in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result word present right after reset");

endmodule

bind four_channel_phase_angle_dimmer pad_checker u_pad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_gates_i (out_o.gates),
  .out_tick_i  (out_o.tick_now),
  .out_delay_i (out_o.delay_set)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] OP_TICK       = pad_pkg::OP_TICK;
  localparam logic [1:0] OP_ZERO_CROSS = pad_pkg::OP_ZERO_CROSS;
  localparam logic [1:0] OP_SET_LEVEL  = pad_pkg::OP_SET_LEVEL;
  // Code 3 is not a member of op_e; the block must leave its state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 64;
  localparam int MAX_REPORTS = 100;
  localparam int DIR_N = 15;

  typedef struct packed {
    logic [3:0]  gates;
    logic [15:0] tick;
    logic [11:0] delay;
  } dimmer_out_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  ch;
    logic [7:0]  lvl;
    logic        typed;
    dimmer_out_t res;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  pad_in_if  in_if ();
  pad_out_if out_if ();

  four_channel_phase_angle_dimmer #(
    .NUM_CHANNELS(4)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Dimmer state as the testbench sees it.
  pad_pkg::cfg_t cfg_q;
  logic [15:0]   tick_q;
  logic [7:0]    pulse_q;
  logic [11:0]   pend_q [4];
  logic [11:0]   act_q [4];
  logic [3:0]    gate_q;

  dimmer_out_t dimmer_results_q [$];
  dimmer_out_t oldest_res;
  int          err_cnt = 0;
  int unsigned cyc_cnt = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  // With the reset settings, level 0 clamps to the floor (80 ticks) and
  // level 255 clamps to the ceiling (750 ticks).
  dir_row_t dir_tab [0:DIR_N-1] = '{
    '{OP_TICK,       2'd0, 8'd0,   1'b1, '{4'd0, 16'd1, 12'd0}},
    '{OP_UNUSED,     2'd3, 8'd255, 1'b1, '{4'd0, 16'd1, 12'd0}},
    '{OP_SET_LEVEL,  2'd0, 8'd0,   1'b1, '{4'd0, 16'd1, 12'd80}},
    '{OP_SET_LEVEL,  2'd1, 8'd255, 1'b1, '{4'd0, 16'd1, 12'd750}},
    '{OP_SET_LEVEL,  2'd2, 8'd26,  1'b0, '0},
    '{OP_SET_LEVEL,  2'd3, 8'd230, 1'b0, '0},
    '{OP_SET_LEVEL,  2'd2, 8'h55,  1'b0, '0},
    '{OP_SET_LEVEL,  2'd3, 8'haa,  1'b0, '0},
    '{OP_ZERO_CROSS, 2'd0, 8'd0,   1'b1, '{4'd0, 16'd0, 12'd0}},
    '{OP_TICK,       2'd3, 8'hff,  1'b0, '0},
    '{OP_TICK,       2'd0, 8'd0,   1'b0, '0},
    '{OP_UNUSED,     2'd0, 8'd0,   1'b0, '0},
    '{OP_SET_LEVEL,  2'd3, 8'h80,  1'b0, '0},
    '{OP_ZERO_CROSS, 2'd1, 8'h7f,  1'b0, '0},
    '{OP_TICK,       2'd2, 8'h01,  1'b0, '0}
  };

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic dimmer_out_t dimmer_step(logic [1:0] op, logic [1:0] ch,
                                              logic [7:0] lvl);
    dimmer_out_t r;
    logic [7:0]  l;
    logic [15:0] prod;
    r = '0;
    case (op)
      OP_TICK: begin
        tick_q = tick_q + 16'd1;
        // A running pulse is counted first, so a channel firing on this
        // tick restarts the pulse after the drop.
        if (pulse_q != 8'd0) begin
          pulse_q = pulse_q + 8'd1;
          if (pulse_q == cfg_q.pulse_length) begin
            gate_q  = '0;
            pulse_q = '0;
          end
        end
        for (int k = 0; k < 4; k++) begin
          if ({4'd0, act_q[k]} == tick_q) begin
            gate_q[k] = 1'b1;
            pulse_q   = 8'd1;
          end
        end
      end
      OP_ZERO_CROSS: begin
        act_q  = pend_q;
        tick_q = '0;
      end
      OP_SET_LEVEL: begin
        // Floor first, then ceiling, so the ceiling wins when they cross.
        l = lvl;
        if (l < cfg_q.level_floor) l = cfg_q.level_floor;
        if (l > cfg_q.level_ceiling) l = cfg_q.level_ceiling;
        prod = l * cfg_q.scale_factor;
        r.delay = 12'((prod >> 8) * 10);
        pend_q[ch] = r.delay;
      end
      default: ;
    endcase
    r.gates = gate_q;
    r.tick  = tick_q;
    return r;
  endfunction

  // Offers one word; returns at the edge where it is taken, with valid left
  // high so a following word can go out back to back.
  task automatic send_word(logic [1:0] op, logic [1:0] ch, logic [7:0] lvl,
                           bit typed = 1'b0, dimmer_out_t typed_res = '0);
    int gap;
    dimmer_out_t res;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.opcode  <= op;
    in_if.channel <= ch;
    in_if.level   <= lvl;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    res = dimmer_step(op, ch, lvl);
    dimmer_results_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (dimmer_results_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pad_pkg::REG_PULSE_LENGTH:  cfg_q.pulse_length  = data;
      pad_pkg::REG_SCALE_FACTOR:  cfg_q.scale_factor  = data;
      pad_pkg::REG_LEVEL_FLOOR:   cfg_q.level_floor   = data;
      pad_pkg::REG_LEVEL_CEILING: cfg_q.level_ceiling = data;
      default: ;
    endcase
  endtask

  task automatic set_cfg(logic [7:0] pl, logic [7:0] sf, logic [7:0] fl, logic [7:0] ce);
    write_reg(pad_pkg::REG_PULSE_LENGTH, pl);
    write_reg(pad_pkg::REG_SCALE_FACTOR, sf);
    write_reg(pad_pkg::REG_LEVEL_FLOOR, fl);
    write_reg(pad_pkg::REG_LEVEL_CEILING, ce);
  endtask

  task automatic random_cfg();
    set_cfg(($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(2, 12)),
            8'($urandom_range(1, 12)), 8'($urandom_range(0, 100)),
            8'($urandom_range(100, 255)));
  endtask

  // Mains half-cycles: at times one to four level changes, a zero crossing, then
  // a run of ticks with the odd stray word mixed in.
  task automatic run_mains(int halves, int span);
    int nt;
    int r;
    for (int h = 0; h < halves; h++) begin
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 4))
          send_word(OP_SET_LEVEL, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      send_word(OP_ZERO_CROSS, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      nt = $urandom_range(span / 2, span);
      for (int i = 0; i < nt; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8)
          send_word(OP_SET_LEVEL, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        else if (r < 10)
          send_word(OP_UNUSED, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        else if (r < 11)
          send_word(OP_ZERO_CROSS, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        else
          send_word(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Result side: short random stalls, plus one long hold on request.
  initial begin : result_sink
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (dimmer_results_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, got gates %0h tick %0d delay %0d",
                   $time, out_if.gates, out_if.tick_now, out_if.delay_set);
      end else begin
        oldest_res = dimmer_results_q.pop_front();
        check_field("gates", oldest_res.gates, out_if.gates);
        check_field("tick_now", oldest_res.tick, out_if.tick_now);
        check_field("delay_set", oldest_res.delay, out_if.delay_set);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    in_if.valid   = 1'b0;
    in_if.opcode  = '0;
    in_if.channel = '0;
    in_if.level   = '0;
    cfg_q   = '{pad_pkg::RST_PULSE_LENGTH, pad_pkg::RST_SCALE_FACTOR,
                pad_pkg::RST_LEVEL_FLOOR, pad_pkg::RST_LEVEL_CEILING};
    tick_q  = '0;
    pulse_q = '0;
    gate_q  = '0;
    for (int k = 0; k < 4; k++) begin
      pend_q[k] = '0;
      act_q[k]  = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_N; i++)
      send_word(dir_tab[i].op, dir_tab[i].ch, dir_tab[i].lvl, dir_tab[i].typed,
                dir_tab[i].res);
    drain();

    // Delays of 0 or 10 ticks with the shortest pulse; the sink holds off
    // at the start so the block backs up into its input.
    set_cfg(8'd2, 8'd2, 8'd0, 8'd255);
    hold_req = 1'b1;
    run_mains(4, 24);
    drain();

    set_cfg(8'd255, 8'd255, 8'd255, 8'd255);
    run_mains(1, 40);
    drain();

    // Every delay is ten ticks, so the gates fire on tick ten; with pulse
    // length 0 they drop again only when the pulse counter wraps to zero.
    set_cfg(8'd0, 8'd2, 8'd0, 8'd255);
    for (int k = 0; k < 4; k++)
      send_word(OP_SET_LEVEL, 2'(k), 8'($urandom_range(128, 255)));
    send_word(OP_ZERO_CROSS, 2'd0, 8'd0);
    repeat (280)
      send_word(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    drain();

    // Floor above ceiling, and pulse length 1 which never drops the gates.
    set_cfg(8'd1, 8'd16, 8'd200, 8'd50);
    run_mains(2, 40);
    drain();

    repeat (2) begin
      random_cfg();
      run_mains(2, 40);
      drain();
    end

    calm = 1'b1;
    random_cfg();
    run_mains(2, 40);
    drain();
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
